// ----- src/mei_pkg.sv -----
// shared constants, types and helpers for the mandelbrot escape iteration unit
package mei_pkg;

  localparam int FIXED_WIDTH   = 32;
  localparam int FRACTION_BITS = 28;
  localparam int PROD_WIDTH    = 2 * FIXED_WIDTH;
  localparam int SUM_WIDTH     = FIXED_WIDTH + 2;
  localparam int CNT_WIDTH     = 8;

  localparam logic [CNT_WIDTH-1:0] ITER_LIMIT_RESET = CNT_WIDTH'(255);

  localparam logic signed [FIXED_WIDTH-1:0] TWO_FX =
    FIXED_WIDTH'(1) << (FRACTION_BITS + 1);
  localparam logic [PROD_WIDTH-1:0] FOUR_SQ =
    PROD_WIDTH'(1) << (2 * FRACTION_BITS + 2);

  localparam logic signed [FIXED_WIDTH-1:0] FX_MAX = {1'b0, {(FIXED_WIDTH-1){1'b1}}};
  localparam logic signed [FIXED_WIDTH-1:0] FX_MIN = {1'b1, {(FIXED_WIDTH-1){1'b0}}};

  typedef logic signed [FIXED_WIDTH-1:0] fx_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic [CNT_WIDTH-1:0]          cnt_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ITER  = 5'b00010,
    ST_SQI   = 5'b00100,
    ST_CROSS = 5'b01000,
    ST_UPD   = 5'b10000
  } state_t;

  function automatic fx_t sat_fx(input sum_t s);
    fx_t r;
    if (s > sum_t'(FX_MAX)) begin
      r = FX_MAX;
    end else if (s < sum_t'(FX_MIN)) begin
      r = FX_MIN;
    end else begin
      r = s[FIXED_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/mei_mul.sv -----
// shared signed multiplier with registered product
module mei_mul (
  input  logic          clk,
  input  mei_pkg::fx_t  a,
  input  mei_pkg::fx_t  b,
  output mei_pkg::prod_t prod_r
);
  import mei_pkg::*;

  prod_t prod_nxt;

  assign prod_nxt = PROD_WIDTH'(a) * PROD_WIDTH'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- src/mandelbrot_escape_iteration_unit.sv -----
// mandelbrot escape-time unit: one point per request, one shared multiplier
// iteration: each one passes ITER, SQI, CROSS and UPD, less the update step on the last one;
//   a point that leaves through the component bound check ends at its first step, ITER
// requests: one request in flight, busy until the result strobe
// the iteration loop on the single multiplier holds off any new request until then
// reset: synchronous active low, the iteration limit returns to 255; results cannot be stalled
module mandelbrot_escape_iteration_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mei_pkg::fx_t         in_c_real,
  input  mei_pkg::fx_t         in_c_imag,
  output logic                 out_valid,
  output mei_pkg::cnt_t        out_iter_count,
  input  logic                 cfg_we,
  input  mei_pkg::cnt_t        cfg_wdata
);
  import mei_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   iter_limit_r;
  cnt_t   iter_r, iter_nxt;
  fx_t    cr_r, ci_r;
  fx_t    zr_r, zr_nxt, zi_r, zi_nxt;
  prod_t  sr_r, sr_nxt;
  prod_t  d_r, d_nxt;
  logic   valid_r, valid_nxt;
  cnt_t   count_r, count_nxt;

  fx_t    mul_a, mul_b;
  prod_t  prod_r;

  logic   big;
  logic [PROD_WIDTH-1:0] mag_sum;
  prod_t  re_w, im_w;
  sum_t   re_s, im_s;

  mei_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = valid_r;
  assign out_iter_count = count_r;

  assign big     = (zr_r >= TWO_FX) || (zr_r <= -TWO_FX) ||
                   (zi_r >= TWO_FX) || (zi_r <= -TWO_FX);
  assign mag_sum = PROD_WIDTH'(sr_r) + PROD_WIDTH'(prod_r);

  // floor shifts of the difference and of the doubled cross product
  assign re_w = d_r >>> FRACTION_BITS;
  assign im_w = (prod_r <<< 1) >>> FRACTION_BITS;
  assign re_s = sum_t'(re_w[SUM_WIDTH-1:0]) + sum_t'(cr_r);
  assign im_s = sum_t'(im_w[SUM_WIDTH-1:0]) + sum_t'(ci_r);

  always_comb begin
    mul_a = zr_r;
    mul_b = zr_r;
    unique case (state_r)
      ST_SQI: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      ST_CROSS: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
      default: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    sr_nxt    = sr_r;
    d_nxt     = d_r;
    valid_nxt = 1'b0;
    count_nxt = count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          iter_nxt  = '0;
          zr_nxt    = '0;
          zi_nxt    = '0;
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        iter_nxt = iter_r + CNT_WIDTH'(1);
        if (big) begin
          valid_nxt = 1'b1;
          count_nxt = iter_r + CNT_WIDTH'(1);
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SQI;
        end
      end
      ST_SQI: begin
        sr_nxt    = prod_r;
        state_nxt = ST_CROSS;
      end
      ST_CROSS: begin
        d_nxt = sr_r - prod_r;
        if ((mag_sum >= FOUR_SQ) || (iter_r >= iter_limit_r)) begin
          valid_nxt = 1'b1;
          count_nxt = iter_r;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        zr_nxt    = sat_fx(re_s);
        zi_nxt    = sat_fx(im_s);
        state_nxt = ST_ITER;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= 1'b0;
      iter_limit_r <= ITER_LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (cfg_we) begin
        iter_limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    iter_r  <= iter_nxt;
    zr_r    <= zr_nxt;
    zi_r    <= zi_nxt;
    sr_r    <= sr_nxt;
    d_r     <= d_nxt;
    count_r <= count_nxt;
    if (state_r == ST_IDLE && start) begin
      cr_r <= in_c_real;
      ci_r <= in_c_imag;
    end
  end

endmodule
